// ===== hw/rtl/snell_refraction_vector_core_macros.svh =====
// Assertion macros for the Snell refraction vector core.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef SNELL_REFRACTION_VECTOR_CORE_MACROS_SVH
`define SNELL_REFRACTION_VECTOR_CORE_MACROS_SVH

// check a condition at every clock edge outside reset
`define SRV_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// check that a condition implies another in the same cycle
`define SRV_CHECK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/srv_pkg.sv =====
// Shared types and constants for the Snell refraction vector core.
// No dependencies; used by the cells and the top level.
package srv_pkg;

  localparam int DivSteps  = 30;
  localparam int SqrtSteps = 31;

  localparam logic [88:0] ONE_Q60_WIDE = 89'h1000_0000_0000_0000;
  localparam logic [61:0] ONE_Q60      = 62'h1000_0000_0000_0000;
  localparam logic [29:0] ONE_Q28      = 30'h1000_0000;
  localparam logic [47:0] TIR_VECTOR   = {16'd0, 16'd0, 16'd16384};

  typedef struct packed {
    logic               valid;
    logic signed [15:0] ix;
    logic signed [15:0] iy;
    logic signed [15:0] iz;
    logic signed [16:0] nx;
    logic signed [16:0] ny;
    logic signed [16:0] nz;
    logic [14:0]        c14;
    logic [28:0]        b;
    logic               tir;
    logic [44:0]        ec;
    logic signed [46:0] iex;
    logic signed [46:0] iey;
    logic signed [46:0] iez;
  } srv_ctx_t;

  typedef struct packed {
    logic [13:0] rem;
    logic [29:0] num;
    logic [13:0] d;
    logic [29:0] q;
  } srv_div_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [61:0] k;
    logic [30:0] root;
  } srv_sqrt_t;

  function automatic logic [15:0] srv_round_sat(input logic signed [65:0] r);
    logic signed [65:0] t;
    logic signed [35:0] q;
    t = r + 66'sd536870912;
    q = t[65:30];
    if (q > 36'sd32767) begin
      return 16'h7fff;
    end else if (q < -36'sd32768) begin
      return 16'h8000;
    end else begin
      return q[15:0];
    end
  endfunction

endpackage

// ===== hw/rtl/srv_div_cell.sv =====
// One restoring-division cell: one quotient bit per cell.
// Depends on srv_pkg.
module srv_div_cell import srv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  srv_ctx_t  ctx_in,
  input  srv_div_t  div_in,
  output srv_ctx_t  ctx_out,
  output srv_div_t  div_out
);

  logic [14:0] sh;
  logic        ge;
  srv_div_t    div_next;

  always_comb begin
    sh = {div_in.rem, div_in.num[29]};
    ge = sh >= {1'b0, div_in.d};
    div_next.rem = ge ? 14'(sh - {1'b0, div_in.d}) : sh[13:0];
    div_next.num = {div_in.num[28:0], 1'b0};
    div_next.d   = div_in.d;
    div_next.q   = {div_in.q[28:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx_out.valid <= 1'b0;
    end else if (en) begin
      ctx_out <= ctx_in;
      div_out <= div_next;
    end
  end

endmodule

// ===== hw/rtl/srv_sqrt_cell.sv =====
// One integer square-root cell: two radicand bits in, one root bit out.
// Depends on srv_pkg.
module srv_sqrt_cell import srv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  srv_ctx_t  ctx_in,
  input  srv_sqrt_t sq_in,
  output srv_ctx_t  ctx_out,
  output srv_sqrt_t sq_out
);

  logic [35:0] sh;
  logic [35:0] trial;
  logic        ge;
  srv_sqrt_t   sq_next;

  always_comb begin
    sh    = {sq_in.rem, sq_in.k[61:60]};
    trial = {3'b0, sq_in.root, 2'b01};
    ge    = sh >= trial;
    sq_next.rem  = ge ? 34'(sh - trial) : sh[33:0];
    sq_next.k    = {sq_in.k[59:0], 2'b00};
    sq_next.root = {sq_in.root[29:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx_out.valid <= 1'b0;
    end else if (en) begin
      ctx_out <= ctx_in;
      sq_out  <= sq_next;
    end
  end

endmodule

// ===== hw/rtl/snell_refraction_vector_core.sv =====
// Snell refraction vector core: refracts a unit direction at a surface.
// Depends on srv_pkg, srv_div_cell, srv_sqrt_cell and the macros header.
//
// Usage:
//   Input stream s_axis_*: one request per cycle carries the incident
//   direction, the surface normal (Q2.14) and the material index (Q2.12).
//   Output stream m_axis_*: the refracted direction (Q2.14, saturated) and
//   a total internal reflection flag in tuser; on reflection the vector is
//   (1,0,0).
//   cfg_we/cfg_wdata write the surrounding-medium index; write it only
//   while no request is in flight.
// Structure: a 30-cell divider row (one quotient bit per cell) and a
//   31-cell square-root row (one root bit per cell) plus nine arithmetic
//   stages.
// Throughput: one request per cycle while the output is not stalled;
//   every cell hands its item on each cycle the pipeline advances.
// Reset: clears all valid bits and sets the outside index to 1.0.
// Stall: while a result waits untaken the whole pipeline holds and
//   s_axis_tready drops; nothing is lost or repeated.
`include "snell_refraction_vector_core_macros.svh"

module snell_refraction_vector_core import srv_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [13:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // incident_x, incident_y, incident_z, normal_x, normal_y, normal_z,
  // material_index, 2 zero bits
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // refracted_x, refracted_y, refracted_z
  output logic [47:0]  m_axis_tdata,
  // internal_reflection
  output logic [0:0]   m_axis_tuser
);

  logic        en;
  logic [13:0] outside_index;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      outside_index <= 14'd4096;
    end else if (cfg_we) begin
      outside_index <= cfg_wdata;
    end
  end

  // stage 1: capture and form the dot-product terms
  logic               s1_valid;
  logic signed [15:0] s1_ix, s1_iy, s1_iz, s1_nx, s1_ny, s1_nz;
  logic [13:0]        s1_mat;
  logic signed [31:0] s1_px, s1_py, s1_pz;
  logic signed [15:0] in_ix, in_iy, in_iz, in_nx, in_ny, in_nz;

  assign in_ix = $signed(s_axis_tdata[15:0]);
  assign in_iy = $signed(s_axis_tdata[31:16]);
  assign in_iz = $signed(s_axis_tdata[47:32]);
  assign in_nx = $signed(s_axis_tdata[63:48]);
  assign in_ny = $signed(s_axis_tdata[79:64]);
  assign in_nz = $signed(s_axis_tdata[95:80]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s_axis_tvalid;
      s1_ix    <= in_ix;
      s1_iy    <= in_iy;
      s1_iz    <= in_iz;
      s1_nx    <= in_nx;
      s1_ny    <= in_ny;
      s1_nz    <= in_nz;
      s1_mat   <= s_axis_tdata[109:96];
      s1_px    <= 32'(in_ix) * 32'(in_nx);
      s1_py    <= 32'(in_iy) * 32'(in_ny);
      s1_pz    <= 32'(in_iz) * 32'(in_nz);
    end
  end

  // stage 2: clamp the cosine, detect a leaving ray, pick the index order
  logic signed [33:0] dot, dotc;
  logic               leaving;
  logic [28:0]        mag;
  srv_ctx_t           s2_next, s2;
  logic [13:0]        s2_from, s2_to;

  always_comb begin
    dot = 34'(s1_px) + 34'(s1_py) + 34'(s1_pz);
    if (dot > 34'sd268435456) begin
      dotc = 34'sd268435456;
    end else if (dot < -34'sd268435456) begin
      dotc = -34'sd268435456;
    end else begin
      dotc = dot;
    end
    leaving = dotc > 34'sd0;
    mag     = leaving ? dotc[28:0] : 29'(-dotc);
    s2_next       = '0;
    s2_next.valid = s1_valid;
    s2_next.ix    = s1_ix;
    s2_next.iy    = s1_iy;
    s2_next.iz    = s1_iz;
    s2_next.nx    = leaving ? -17'(s1_nx) : 17'(s1_nx);
    s2_next.ny    = leaving ? -17'(s1_ny) : 17'(s1_ny);
    s2_next.nz    = leaving ? -17'(s1_nz) : 17'(s1_nz);
    s2_next.c14   = 15'((30'(mag) + 30'd8192) >> 14);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (en) begin
      s2      <= s2_next;
      s2_from <= leaving ? s1_mat : outside_index;
      s2_to   <= leaving ? outside_index : s1_mat;
    end
  end

  // stage 3: sin^2 term and divider load
  srv_ctx_t dctx [0:DivSteps];
  srv_div_t ddiv [0:DivSteps];
  srv_ctx_t s3_next;
  srv_div_t d_load;
  logic [29:0] c14_sq;

  always_comb begin
    c14_sq    = 30'(s2.c14) * 30'(s2.c14);
    s3_next   = s2;
    s3_next.b = 29'(ONE_Q28 - c14_sq);
    d_load.rem = '0;
    d_load.num = {s2_from, 16'd0};
    d_load.d   = s2_to;
    d_load.q   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dctx[0].valid <= 1'b0;
    end else if (en) begin
      dctx[0] <= s3_next;
      ddiv[0] <= d_load;
    end
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    srv_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctx_in  (dctx[i]),
      .div_in  (ddiv[i]),
      .ctx_out (dctx[i+1]),
      .div_out (ddiv[i+1])
    );
  end

  // stage A: eta^2, eta*c and the incident terms
  logic [29:0] eta;
  srv_ctx_t    sa_next, sa;
  logic [59:0] sa_a;

  always_comb begin
    eta         = ddiv[DivSteps].q;
    sa_next     = dctx[DivSteps];
    sa_next.ec  = 45'(eta) * 45'(dctx[DivSteps].c14);
    sa_next.iex = 47'($signed(dctx[DivSteps].ix)) * 47'($signed({1'b0, eta}));
    sa_next.iey = 47'($signed(dctx[DivSteps].iy)) * 47'($signed({1'b0, eta}));
    sa_next.iez = 47'($signed(dctx[DivSteps].iz)) * 47'($signed({1'b0, eta}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa.valid <= 1'b0;
    end else if (en) begin
      sa   <= sa_next;
      sa_a <= 60'(eta) * 60'(eta);
    end
  end

  // stage B: eta^2 * sin^2 in two partial products
  srv_ctx_t    sb;
  logic [58:0] sb_pl, sb_ph;

  always_ff @(posedge clk) begin
    if (rst) begin
      sb.valid <= 1'b0;
    end else if (en) begin
      sb    <= sa;
      sb_pl <= 59'(sa_a[29:0]) * 59'(sa.b);
      sb_ph <= 59'(sa_a[59:30]) * 59'(sa.b);
    end
  end

  // stage C: reflection test and square-root load
  srv_ctx_t  qctx [0:SqrtSteps];
  srv_sqrt_t qs   [0:SqrtSteps];
  logic [88:0] ab;
  srv_ctx_t    sc_next;
  srv_sqrt_t   q_load;

  always_comb begin
    ab          = {sb_ph, 30'd0} + 89'(sb_pl);
    sc_next     = sb;
    sc_next.tir = ab > ONE_Q60_WIDE;
    q_load.rem  = '0;
    q_load.k    = 62'(ONE_Q60 - ab[61:0]);
    q_load.root = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qctx[0].valid <= 1'b0;
    end else if (en) begin
      qctx[0] <= sc_next;
      qs[0]   <= q_load;
    end
  end

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    srv_sqrt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctx_in  (qctx[j]),
      .sq_in   (qs[j]),
      .ctx_out (qctx[j+1]),
      .sq_out  (qs[j+1])
    );
  end

  // stage D: normal terms, split into low and high partial products
  srv_ctx_t           sd;
  logic signed [46:0] term;
  logic signed [24:0] term_lo;
  logic signed [22:0] term_hi;
  logic signed [41:0] sd_lx, sd_ly, sd_lz;
  logic signed [39:0] sd_hx, sd_hy, sd_hz;

  always_comb begin
    term = $signed({2'b00, qctx[SqrtSteps].ec})
         - $signed({16'd0, qs[SqrtSteps].root});
    term_lo = $signed({1'b0, term[23:0]});
    term_hi = term[46:24];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sd.valid <= 1'b0;
    end else if (en) begin
      sd    <= qctx[SqrtSteps];
      sd_lx <= 42'($signed(qctx[SqrtSteps].nx)) * 42'(term_lo);
      sd_ly <= 42'($signed(qctx[SqrtSteps].ny)) * 42'(term_lo);
      sd_lz <= 42'($signed(qctx[SqrtSteps].nz)) * 42'(term_lo);
      sd_hx <= 40'($signed(qctx[SqrtSteps].nx)) * 40'(term_hi);
      sd_hy <= 40'($signed(qctx[SqrtSteps].ny)) * 40'(term_hi);
      sd_hz <= 40'($signed(qctx[SqrtSteps].nz)) * 40'(term_hi);
    end
  end

  // stage E: sum in Q.44
  logic               se_valid, se_tir;
  logic signed [65:0] se_rx, se_ry, se_rz;

  always_ff @(posedge clk) begin
    if (rst) begin
      se_valid <= 1'b0;
    end else if (en) begin
      se_valid <= sd.valid;
      se_tir   <= sd.tir;
      se_rx    <= (66'($signed(sd.iex)) <<< 14) + (66'(sd_hx) <<< 24) + 66'(sd_lx);
      se_ry    <= (66'($signed(sd.iey)) <<< 14) + (66'(sd_hy) <<< 24) + 66'(sd_ly);
      se_rz    <= (66'($signed(sd.iez)) <<< 14) + (66'(sd_hz) <<< 24) + 66'(sd_lz);
    end
  end

  // output register: round, saturate, select the reflection vector
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid   <= se_valid;
      m_axis_tuser[0] <= se_tir;
      m_axis_tdata    <= se_tir ? TIR_VECTOR
                       : {srv_round_sat(se_rz), srv_round_sat(se_ry), srv_round_sat(se_rx)};
    end
  end

  `SRV_CHECK(a_c14_range, !s2.valid || s2.c14 <= 15'd16384, "cosine above one")
  `SRV_CHECK_IMP(a_div_rem, dctx[DivSteps].valid && ddiv[DivSteps].d != 14'd0, ddiv[DivSteps].rem < ddiv[DivSteps].d, "divider remainder not below divisor")
  `SRV_CHECK_IMP(a_k_range, qctx[0].valid && !qctx[0].tir, qs[0].k <= ONE_Q60, "radicand above one")
  `SRV_CHECK_IMP(a_tir_vector, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == TIR_VECTOR, "reflection vector wrong")

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for snell_refraction_vector_core: refracts directed and
// random rays under several stall patterns and medium indexes, checking each result
// against a local fixed-point predictor. Depends on the RTL and srv_pkg only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] ix, iy, iz, nx, ny, nz;
    logic [13:0]        mat;
  } ray_t;

  typedef struct {
    logic [15:0] rx, ry, rz;
    logic        tir;
  } bend_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         cfg_we = 0;
  logic [13:0]  cfg_wdata = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [47:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  ray_t   ray_q[$];
  bend_t  bend_q[$];
  ray_t   ray_cur;
  logic [13:0] outside_n = 14'd4096;
  int     src_idle = 0;
  int     sink_stall = 0;
  int     errors = 0;

  snell_refraction_vector_core uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] round_q14(longint r);
    longint q;
    q = (r + (longint'(1) <<< 29)) >>> 30;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic bend_t refract(ray_t it, logic [13:0] outer);
    bend_t o;
    longint ix, iy, iz, nx, ny, nz, c, term, eta_s;
    longint unsigned nf, nt, c14, eta, a, b, k, root;
    ix = longint'(it.ix); iy = longint'(it.iy); iz = longint'(it.iz);
    nx = longint'(it.nx); ny = longint'(it.ny); nz = longint'(it.nz);
    nf = 64'(outer); nt = 64'(it.mat);
    c = ix * nx + iy * ny + iz * nz;
    if (c > (longint'(1) <<< 28)) c = longint'(1) <<< 28;
    if (c < -(longint'(1) <<< 28)) c = -(longint'(1) <<< 28);
    c = -c;
    if (c < 0) begin
      c = -c;
      nx = -nx; ny = -ny; nz = -nz;
      nf = 64'(it.mat); nt = 64'(outer);
    end
    c14 = (longint'(c) + 8192) >> 14;
    eta = (nt == 0) ? ((64'd1 << 30) - 1) : (nf << 16) / nt;
    a = eta * eta;
    b = (64'd1 << 28) - c14 * c14;
    if (b != 0 && a > (64'd1 << 60) / b) begin
      o.rx = 16'd16384; o.ry = '0; o.rz = '0; o.tir = 1'b1;
      return o;
    end
    k = (64'd1 << 60) - a * b;
    root = int_sqrt(k);
    term = longint'(eta * c14) - longint'(root);
    eta_s = longint'(eta);
    o.rx = round_q14(ix * eta_s * 16384 + nx * term);
    o.ry = round_q14(iy * eta_s * 16384 + ny * term);
    o.rz = round_q14(iz * eta_s * 16384 + nz * term);
    o.tir = 1'b0;
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) bend_q = {bend_q, refract(ray_cur, outside_n)};
      if (ray_q.size() > 0 && $urandom_range(99) >= src_idle) begin
        ray_cur = ray_q.pop_front();
        s_axis_tvalid <= 1;
        s_axis_tdata <= {2'b00, ray_cur.mat, ray_cur.nz, ray_cur.ny, ray_cur.nx,
                         ray_cur.iz, ray_cur.iy, ray_cur.ix};
      end else begin
        s_axis_tvalid <= 0;
      end
    end
  end

  always @(posedge clk) begin
    bend_t e;
    if (rst) begin
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall);
      if (m_axis_tvalid && m_axis_tready) begin
        if (bend_q.size() == 0) begin
          $display("%0t: unexpected result %h tir %b", $time, m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          e = bend_q.pop_front();
          if ({e.rz, e.ry, e.rx} !== m_axis_tdata) begin
            $display("%0t: vector expected %h actual %h", $time,
                     {e.rz, e.ry, e.rx}, m_axis_tdata);
            errors++;
          end
          if (e.tir !== m_axis_tuser[0]) begin
            $display("%0t: reflection flag expected %b actual %b", $time,
                     e.tir, m_axis_tuser[0]);
            errors++;
          end
        end
      end
    end
  end

  task automatic add_ray(int ix, int iy, int iz, int nx, int ny, int nz, int mat);
    ray_t r;
    r.ix = 16'(ix); r.iy = 16'(iy); r.iz = 16'(iz);
    r.nx = 16'(nx); r.ny = 16'(ny); r.nz = 16'(nz); r.mat = 14'(mat);
    ray_q = {ray_q, r};
  endtask

  task automatic add_random_ray();
    real vx, vy, vz, len;
    ray_t r;
    int mat;
    if ($urandom_range(99) < 25) begin
      r.ix = 16'($urandom); r.iy = 16'($urandom); r.iz = 16'($urandom);
      r.nx = 16'($urandom); r.ny = 16'($urandom); r.nz = 16'($urandom);
    end else begin
      vx = $itor($urandom_range(2000)) - 1000.0;
      vy = $itor($urandom_range(2000)) - 1000.0;
      vz = $itor($urandom_range(2000)) - 1000.0;
      len = $sqrt(vx * vx + vy * vy + vz * vz) + 0.001;
      r.ix = 16'($rtoi(vx / len * 16384.0));
      r.iy = 16'($rtoi(vy / len * 16384.0));
      r.iz = 16'($rtoi(vz / len * 16384.0));
      vx = $itor($urandom_range(2000)) - 1000.0;
      vy = $itor($urandom_range(2000)) - 1000.0;
      vz = $itor($urandom_range(2000)) - 1000.0;
      len = $sqrt(vx * vx + vy * vy + vz * vz) + 0.001;
      r.nx = 16'($rtoi(vx / len * 16384.0));
      r.ny = 16'($rtoi(vy / len * 16384.0));
      r.nz = 16'($rtoi(vz / len * 16384.0));
    end
    mat = ($urandom_range(99) < 20) ? $urandom_range(16383) : $urandom_range(8000, 4096);
    r.mat = 14'(mat);
    ray_q = {ray_q, r};
  endtask

  task automatic drain();
    while (ray_q.size() > 0 || s_axis_tvalid || bend_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_outside(logic [13:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    outside_n = v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    int src_pct[5] = '{0, 62, 0, 20, 0};
    int sink_pct[5] = '{0, 0, 62, 20, 0};
    logic [13:0] idx_set[5] = '{14'd1024, 14'd16383, 14'd6144, 14'd0, 14'd5461};
    repeat (11) @(posedge clk);
    rst <= 0;
    add_ray(16384, 0, 0, -16384, 0, 0, 6144);
    add_ray(0, 0, -16384, 0, 0, 16384, 16383);
    add_ray(11585, 0, -11585, 0, 0, 16384, 6144);
    add_ray(11585, 0, 11585, 0, 0, 16384, 6144);
    add_ray(16000, 0, 3000, 0, 0, 16384, 6144);
    add_ray(16384, 0, 0, 0, 0, 16384, 6144);
    add_ray(0, 0, 0, 0, 0, 0, 4096);
    add_ray(-32768, -32768, -32768, -32768, -32768, -32768, 4096);
    add_ray(32767, 32767, 32767, -32768, -32768, -32768, 1024);
    add_ray(32767, -32768, 32767, 32767, -32768, 32767, 16383);
    add_ray(16384, 0, 0, -16384, 0, 0, 0);
    add_ray(16384, 0, 0, 16384, 0, 0, 0);
    add_ray(0, 16384, 0, 0, -16384, 0, 1024);
    add_ray(0, 11585, 11585, 0, 0, -16384, 16383);
    add_ray(-16384, 0, 0, 16384, 0, 0, 2048);
    add_ray(1, -1, 16383, 0, 0, 16384, 8191);
    drain();
    for (int p = 0; p < 5; p++) begin
      write_outside(idx_set[p]);
      src_idle = src_pct[p];
      sink_stall = sink_pct[p];
      for (int i = 0; i < 230; i++) add_random_ray();
      drain();
    end
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_top failed");
    $finish;
  end
endmodule
